>>> rtl/dws_pkg.sv
`timescale 1ns / 1ps

package dws_pkg;

  // Store geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [AW-1:0]         addr_t;
  typedef logic [CW-1:0]         count_t;

endpackage

>>> rtl/deque_with_search.sv
`timescale 1ns / 1ps
// Pushes, errors and ignored codes finish on acceptance: a push or error result
// goes to the output register at the accepting edge; ignored codes give none.
// Pops make one RAM read and load its data. Search reads entries from the front
// until a match or the last one; dump gives one item per cycle unless stalled,
// one RAM read each. One command is worked at a time. rst_n (synchronous, active
// low) empties the deque at once; the entry RAM is not cleared, nor needs to be.

module deque_with_search import dws_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [VALUE_W-1:0]  in_item_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic [POS_W-1:0]           out_found_position,
  output logic                       out_last_of_run
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state_r, state_nxt;
  addr_t            front_r, front_nxt;
  count_t           count_r, count_nxt;
  count_t           idx_r, idx_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  data_t            key_r, key_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;

  logic  out_free, accept, out_load, full, empty, last_idx;
  data_t in_data, rd_data, wr_data;
  addr_t wr_addr, rd_addr;
  logic  wr_en, rd_en;

  // Ring position of the entry pos places behind base.
  function automatic addr_t ring_slot(addr_t base, count_t pos);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(pos);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign last_idx = (idx_r == count_r - CW'(1));
  assign in_data  = DATA_WIDTH'(in_item_value);

  dws_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Command decode on accept and the entry walk for pop, search and dump.
  // Writes only happen at accept and reads complete before the next accept,
  // so a read never overlaps a write to the same entry.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    wr_en          = 1'b0;
    wr_addr        = ring_slot(front_r, count_r);
    wr_data        = in_data;
    rd_en          = 1'b0;
    rd_addr        = front_r;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_pos_nxt    = '0;
    out_last_nxt   = 1'b1;

    if (state_r == S_IDLE) begin
      if (accept) begin
        cmd_nxt = in_cmd;
        key_nxt = in_data;
        idx_nxt = '0;
        case (in_cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            out_load = 1'b1;
            if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
              if (in_cmd == CMD_PUSH_FRONT) begin
                front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
                wr_addr   = front_nxt;
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK, CMD_SEARCH, CMD_DUMP: begin
            if (empty) begin
              out_load       = 1'b1;
              out_status_nxt = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_SCAN;
              if (in_cmd == CMD_POP_FRONT) begin
                front_nxt = ring_slot(front_r, CW'(1));
                count_nxt = count_r - CW'(1);
              end else if (in_cmd == CMD_POP_BACK) begin
                rd_addr   = ring_slot(front_r, count_r - CW'(1));
                count_nxt = count_r - CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      rd_addr = ring_slot(front_r, idx_r + CW'(1));
      case (cmd_r)
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (out_free) begin
            out_load      = 1'b1;
            out_value_nxt = VALUE_W'(rd_data);
            state_nxt     = S_IDLE;
          end
        end
        CMD_SEARCH: begin
          if (rd_data == key_r) begin
            if (out_free) begin
              out_load      = 1'b1;
              out_value_nxt = VALUE_W'(key_r);
              out_pos_nxt   = POS_W'(idx_r + CW'(1));
              state_nxt     = S_IDLE;
            end
          end else if (last_idx) begin
            if (out_free) begin
              out_load       = 1'b1;
              out_status_nxt = ST_MISS;
              state_nxt      = S_IDLE;
            end
          end else begin
            rd_en   = 1'b1;
            idx_nxt = idx_r + CW'(1);
          end
        end
        CMD_DUMP: begin
          if (out_free) begin
            out_load      = 1'b1;
            out_value_nxt = VALUE_W'(rd_data);
            out_last_nxt  = last_idx;
            if (last_idx) begin
              state_nxt = S_IDLE;
            end else begin
              rd_en   = 1'b1;
              idx_nxt = idx_r + CW'(1);
            end
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // The output register is held while stalled and cleared once taken.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Work registers and result payload.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_pos_r    <= out_pos_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value          = out_value_r;
  assign out_found_position = out_pos_r;
  assign out_last_of_run    = out_last_r;

  // The fill count never goes past the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // A successful push grows the deque by exactly one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the deque");

  // Pointers do not move while a command is being walked.
  a_ptr_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> ($stable(count_r) && $stable(front_r)))
    else $error("pointers moved during a walk");

  // The final item of a command returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("block busy after last item");

  // A new item is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output item overwritten");

endmodule

>>> rtl/dws_ram.sv
`timescale 1ns / 1ps

module dws_ram import dws_pkg::*; (
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  data_t wr_data,
  input  logic  rd_en,
  input  addr_t rd_addr,
  output data_t rd_data
);

  data_t mem [DEPTH];
  data_t rd_data_r;

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sim/deque_with_search_tb.sv
`timescale 1ns / 1ps

module deque_with_search_tb;
  import dws_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_LEN   = 6;
  localparam int CMD_TARGET  = 500;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_LEN    = 120;
  localparam int SETTLE_AT   = 300;
  localparam int TAIL_WAIT   = 40;

  // Codes that the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    data_t            value;
    bit               settle;  // wait until every result is back before sending
  } deque_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    data_t               value;
    logic [POS_W-1:0]    pos;
    logic                last;
  } deque_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_cmd = CMD_PUSH_FRONT;
  logic signed [VALUE_W-1:0] in_item_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]          out_found_position;
  logic                      out_last_of_run;

  deque_cmd_t    pending[$];
  deque_result_t due_results[$];

  // Shadow copy of the deque contents.
  data_t       ring [DEPTH];
  addr_t       head = '0;
  int unsigned fill = 0;

  int  n_due = 0;
  int  n_checked = 0;
  int  n_accepted = 0;
  int  n_cmds = 0;
  int  cycles = 0;
  bit  failed = 1'b0;
  int  send_gap = 0, send_calm = 0, send_roll;
  int  stall_left = 0, calm_left = 0, hold_left = 0, recv_roll;
  bit  hold_done = 1'b0;

  deque_with_search DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_value          (out_value),
    .out_found_position (out_found_position),
    .out_last_of_run    (out_last_of_run)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Values come half the time from a small pool so that searches hit and repeat.
  function automatic data_t pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return '0;
      4, 5, 6, 7: return data_t'($urandom_range(1, 6));
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input data_t value);
    pending.push_back('{cmd: cmd, value: value, settle: (n_cmds == SETTLE_AT)});
    if (cmd <= CMD_DUMP) n_cmds++;
  endtask

  // Apply one command to the shadow deque and queue the results it causes.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input data_t value);
    deque_result_t r;
    bit            emit_one;
    int unsigned   k;
    r = '{status: ST_OK, value: '0, pos: '0, last: 1'b1};
    emit_one = 1'b1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head = head - addr_t'(1);
            ring[head] = value;
          end else begin
            ring[addr_t'(head + fill)] = value;
          end
          fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          r.value = ring[head];
          head = head + addr_t'(1);
          fill--;
        end else begin
          r.value = ring[addr_t'(head + fill - 1)];
          fill--;
        end
      end
      CMD_SEARCH: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // The scan covers every live entry, the tail included.
          r.status = ST_MISS;
          for (k = 0; k < fill; k++) begin
            if (r.status == ST_MISS && ring[addr_t'(head + k)] == value) begin
              r.status = ST_OK;
              r.value  = value;
              r.pos    = POS_W'(k + 1);
            end
          end
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          emit_one = 1'b0;
          for (k = 0; k < fill; k++) begin
            r.value = ring[addr_t'(head + k)];
            r.last  = (k + 1 == fill);
            due_results.push_back(r);
            n_due++;
          end
        end
      end
      default: begin
        // Unused codes change nothing and produce nothing.
        emit_one = 1'b0;
      end
    endcase
    if (emit_one) begin
      due_results.push_back(r);
      n_due++;
    end
  endtask

  // Driver: present pending items, predict on acceptance, insert random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        apply_command(in_cmd, in_item_value);
        n_accepted <= n_accepted + 1;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_roll = $urandom_range(0, 99);
          if (send_roll < 4) send_calm = $urandom_range(20, 60);
          else if (send_roll < 30) send_gap = pick_pause();
        end
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() != 0 && (!pending[0].settle || n_checked >= n_due)) begin
        in_valid      <= 1'b1;
        in_cmd        <= pending[0].cmd;
        in_item_value <= pending[0].value;
        void'(pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, quiet stretches and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      recv_roll = $urandom_range(0, 99);
      if (recv_roll < 8) begin
        calm_left = $urandom_range(20, 60);
        out_stall <= 1'b0;
      end else if (recv_roll < 33) begin
        stall_left = pick_pause() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d value %h position %0d last %0b",
               out_status, out_value, out_found_position, out_last_of_run);
        failed = 1'b1;
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          failed = 1'b1;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %h, actual %h", want.value, out_value);
          failed = 1'b1;
        end
        if (out_found_position !== want.pos) begin
          $error("found_position: expected %0d, actual %0d", want.pos, out_found_position);
          failed = 1'b1;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, out_last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("deque_with_search verification failed");
      $finish;
    end
  end

  initial begin
    int kind, len, j, roll;

    // Directed part: underflow on every reader, extremes, first match, tail search.
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_POP_BACK, '0);
    queue_cmd(CMD_SEARCH, '0);
    queue_cmd(CMD_DUMP, '0);
    queue_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff);
    queue_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    queue_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
    queue_cmd(CMD_PUSH_BACK, '0);
    queue_cmd(CMD_SEARCH, '0);
    queue_cmd(CMD_SEARCH, 32'h7fff_ffff);
    queue_cmd(CMD_SEARCH, 32'd12345);
    queue_cmd(CMD_PUSH_BACK, 32'h7fff_ffff);
    queue_cmd(CMD_SEARCH, 32'h7fff_ffff);
    queue_cmd(CMD_DUMP, '0);
    queue_cmd(CMD_UNUSED_6, 32'h5555_5555);
    queue_cmd(CMD_UNUSED_7, 32'haaaa_aaaa);
    queue_cmd(CMD_POP_BACK, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_POP_BACK, '0);
    queue_cmd(CMD_POP_BACK, '0);
    queue_cmd(CMD_POP_BACK, '0);

    // Random part: fill runs to overflow, drain runs to underflow, and mixed traffic.
    while (n_cmds < CMD_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        len = $urandom_range(17, 20);
        for (j = 0; j < len; j++)
          queue_cmd(($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
      end else if (kind < 4) begin
        len = $urandom_range(17, 20);
        for (j = 0; j < len; j++)
          queue_cmd(($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
      end else begin
        len = $urandom_range(5, 15);
        for (j = 0; j < len; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 20) queue_cmd(CMD_PUSH_FRONT, pick_value());
          else if (roll < 40) queue_cmd(CMD_PUSH_BACK, pick_value());
          else if (roll < 52) queue_cmd(CMD_POP_FRONT, pick_value());
          else if (roll < 65) queue_cmd(CMD_POP_BACK, pick_value());
          else if (roll < 85) queue_cmd(CMD_SEARCH, pick_value());
          else if (roll < 95) queue_cmd(CMD_DUMP, pick_value());
          else queue_cmd(($urandom_range(0, 1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7,
                         pick_value());
        end
      end
    end

    // Reset once at the start.
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all items to go in and all results to come back.
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || n_checked < n_due);
    repeat (TAIL_WAIT) @(negedge clk);

    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      failed = 1'b1;
    end
    if (failed) begin
      $display("deque_with_search verification failed");
    end else begin
      $display("deque_with_search verification clean");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dws_pkg.sv
rtl/dws_ram.sv
rtl/deque_with_search.sv
sim/deque_with_search_tb.sv
